// File: src/imao_pkg.sv
// shared types and constants for the imu moving average offset core
// no dependencies; used by every module under src
package imao_pkg;

   localparam int WINDOW_DEF = 10;
   localparam int CALIB_DEF  = 100;
   localparam int WARMUP_DEF = 100;

   localparam int NUM_CH   = 6;
   localparam int NUM_GYRO = 3;
   localparam int SAMP_W   = 16;
   localparam int SUM_W    = 20;
   localparam int ACC_W    = 24;
   localparam int COUNT_W  = 8;

   typedef logic signed [SAMP_W-1:0] samp_type;
   typedef samp_type [NUM_CH-1:0] samp_vec_type;
   typedef samp_type [NUM_GYRO-1:0] gyro_vec_type;

   typedef struct packed {
      logic signed [SAMP_W-1:0] gyro_x_raw;
      logic signed [SAMP_W-1:0] gyro_y_raw;
      logic signed [SAMP_W-1:0] gyro_z_raw;
      logic signed [SAMP_W-1:0] accel_x_raw;
      logic signed [SAMP_W-1:0] accel_y_raw;
      logic signed [SAMP_W-1:0] accel_z_raw;
   } req_type;

   typedef struct packed {
      logic signed [SAMP_W-1:0] gyro_x_out;
      logic signed [SAMP_W-1:0] gyro_y_out;
      logic signed [SAMP_W-1:0] gyro_z_out;
      logic signed [SAMP_W-1:0] accel_x_out;
      logic signed [SAMP_W-1:0] accel_y_out;
      logic signed [SAMP_W-1:0] accel_z_out;
      logic                     calibrating;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_WARM,
      PH_ACC,
      PH_LATCH,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic calib;
      logic acc;
      logic last;
   } tag_type;

   typedef struct packed {
      logic         acc_en;
      logic         last;
      gyro_vec_type g;
   } bias_upd_type;

   typedef struct packed {
      logic         done;
      gyro_vec_type offset;
   } bias_stat_type;

endpackage

// File: src/imao_ring_mem.sv
// sample ring memory: one row of six samples per window slot, registered read
// rows read as zero until first written; depends on imao_pkg
module imao_ring_mem #(
   parameter int WINDOW = imao_pkg::WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [$clog2(WINDOW)-1:0]  rd_slot,
   output imao_pkg::samp_vec_type     rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(WINDOW)-1:0]  wr_slot,
   input  imao_pkg::samp_vec_type     wr_data
);

   imao_pkg::samp_vec_type ring_mem [WINDOW];
   logic [WINDOW-1:0]      row_valid_ff;
   imao_pkg::samp_vec_type rd_q_ff;
   logic                   rd_ok_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_slot] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= ring_mem[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_slot] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= row_valid_ff[rd_slot];
         end
      end
   end

   assign rd_data = rd_ok_ff ? rd_q_ff : '0;

endmodule

// File: src/imao_bias_cal.sv
// gyro bias accumulators and offset latch with reciprocal-multiply divide
// depends on imao_pkg
module imao_bias_cal #(
   parameter int CALIB = imao_pkg::CALIB_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  imao_pkg::bias_upd_type  upd,
   output imao_pkg::bias_stat_type stat
);

   localparam int AccW      = imao_pkg::ACC_W;
   localparam int SampW     = imao_pkg::SAMP_W;
   localparam int CalShift  = 31;
   localparam int CalRecipW = 32;
   localparam int CalProdW  = AccW + CalRecipW;
   localparam logic [CalRecipW-1:0] CalRecip =
      CalRecipW'(((64'd1 << CalShift) + 64'(CALIB) - 64'd1) / 64'(CALIB));

   logic signed [AccW-1:0]  acc_ff  [imao_pkg::NUM_GYRO];
   logic signed [AccW-1:0]  acc_in  [imao_pkg::NUM_GYRO];
   logic [AccW-1:0]         abs_in  [imao_pkg::NUM_GYRO];
   logic                    l1_valid_ff;
   logic [AccW-1:0]         l1_abs_ff [imao_pkg::NUM_GYRO];
   logic                    l1_neg_ff [imao_pkg::NUM_GYRO];
   logic                    l2_valid_ff;
   logic [CalProdW-1:0]     l2_prod_ff [imao_pkg::NUM_GYRO];
   logic                    l2_neg_ff  [imao_pkg::NUM_GYRO];
   logic [SampW-1:0]        off_in  [imao_pkg::NUM_GYRO];
   imao_pkg::gyro_vec_type  offset_ff;
   logic                    done_ff;

   always_comb begin
      for (int c = 0; c < imao_pkg::NUM_GYRO; c++) begin
         acc_in[c] = acc_ff[c] + AccW'($signed(upd.g[c]));
         abs_in[c] = acc_in[c][AccW-1] ? AccW'(-acc_in[c]) : AccW'(acc_in[c]);
      end
   end

   always_comb begin
      for (int c = 0; c < imao_pkg::NUM_GYRO; c++) begin
         off_in[c] = l2_prod_ff[c][CalShift +: SampW];
         if (l2_neg_ff[c]) begin
            off_in[c] = ~off_in[c] + SampW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < imao_pkg::NUM_GYRO; c++) begin
         l1_abs_ff[c]  <= abs_in[c];
         l1_neg_ff[c]  <= acc_in[c][AccW-1];
         l2_prod_ff[c] <= CalProdW'(l1_abs_ff[c]) * CalProdW'(CalRecip);
         l2_neg_ff[c]  <= l1_neg_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < imao_pkg::NUM_GYRO; c++) begin
            acc_ff[c] <= '0;
         end
         offset_ff   <= '0;
         l1_valid_ff <= 1'b0;
         l2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         if (upd.acc_en) begin
            for (int c = 0; c < imao_pkg::NUM_GYRO; c++) begin
               acc_ff[c] <= acc_in[c];
            end
         end
         l1_valid_ff <= upd.acc_en && upd.last;
         l2_valid_ff <= l1_valid_ff;
         done_ff     <= l2_valid_ff;
         if (l2_valid_ff) begin
            for (int c = 0; c < imao_pkg::NUM_GYRO; c++) begin
               offset_ff[c] <= off_in[c];
            end
         end
      end
   end

   assign stat.done   = done_ff;
   assign stat.offset = offset_ff;

endmodule

// File: src/imao_out_fifo.sv
// result queue between the filter pipeline and the rsp channel
// depends on imao_pkg
module imao_out_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  imao_pkg::rsp_type push_data,
   input  logic              pop,
   output logic              not_empty,
   output imao_pkg::rsp_type head_data
);

   localparam int PtrW   = $clog2(DEPTH);
   localparam int CountW = $clog2(DEPTH + 1);

   imao_pkg::rsp_type queue_mem [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_in;
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_data = queue_mem[rd_ptr_ff];

endmodule

// File: src/imu_moving_average_offset_core.sv
// top level of the imu moving average offset core
// uses imao_pkg, imao_ring_mem, imao_bias_cal and imao_out_fifo
//
// req channel: one six-channel sample per transfer (req_valid, req_stall, req_data).
// rsp channel: one filtered result per sample, in order (rsp_valid, rsp_stall, rsp_data).
// result path: each sample passes the p1, p2 and p3 registers, then the output queue.
// throughput: one sample per cycle while req_stall is low; the ring memory is read in
// the transfer cycle, the running sums update in the cycle after, and a four-entry
// credit covers the pipeline and queue. once after reset, req_stall stays high after the
// sample that completes bias accumulation while the offsets are divided out and latched.
// rsp_stall: results collect in a four-entry queue; req_stall rises once four
// samples are in flight or queued and no result leaves that cycle.
// reset: synchronous; clears the ring valid bits, running sums, phase counter,
// accumulators and offsets at once, with no clearing pass, so the next cycle
// already takes samples.
module imu_moving_average_offset_core #(
   parameter int WINDOW = imao_pkg::WINDOW_DEF,
   parameter int CALIB  = imao_pkg::CALIB_DEF,
   parameter int WARMUP = imao_pkg::WARMUP_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  imao_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output imao_pkg::rsp_type rsp_data
);

   localparam int NumCh     = imao_pkg::NUM_CH;
   localparam int NumGyro   = imao_pkg::NUM_GYRO;
   localparam int SampW     = imao_pkg::SAMP_W;
   localparam int SumW      = imao_pkg::SUM_W;
   localparam int CountW    = imao_pkg::COUNT_W;
   localparam int SlotW     = $clog2(WINDOW);
   localparam int WinShift  = 23;
   localparam int WinRecipW = 24;
   localparam int ProdW     = SumW + WinRecipW;
   localparam int AvgW      = SampW + 1;
   localparam int DiffW     = SampW + 2;
   localparam int FifoDepth = 4;
   localparam int FillW     = $clog2(FifoDepth + 1);
   localparam logic [WinRecipW-1:0] WinRecip =
      WinRecipW'(((64'd1 << WinShift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
   localparam logic [CountW-1:0] WarmLast  = CountW'(WARMUP - 1);
   localparam logic [CountW-1:0] CalibLast = CountW'(CALIB - 1);
   localparam logic signed [DiffW-1:0] SatMax = DiffW'(32767);
   localparam logic signed [DiffW-1:0] SatMin = -DiffW'(32768);

   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    hold;

   imao_pkg::phase_type     phase_ff;
   imao_pkg::phase_type     phase_in;
   logic [CountW-1:0]       count_ff;
   logic [CountW-1:0]       count_in;
   imao_pkg::tag_type       tag_in;
   logic [SlotW-1:0]        slot_ff;
   logic [SlotW-1:0]        slot_in;
   logic [FillW-1:0]        fill_ff;
   logic [FillW-1:0]        fill_in;

   imao_pkg::samp_vec_type  samp_in;
   imao_pkg::samp_vec_type  old_samp;

   logic                    p1_valid_ff;
   imao_pkg::samp_vec_type  p1_samp_ff;
   logic [SlotW-1:0]        p1_slot_ff;
   imao_pkg::tag_type       p1_tag_ff;

   logic signed [SumW-1:0]  sums_ff [NumCh];
   logic signed [SumW-1:0]  sums_in [NumCh];

   logic                    p2_valid_ff;
   logic signed [SumW-1:0]  p2_sum_ff [NumCh];
   imao_pkg::tag_type       p2_tag_ff;
   logic [SumW-1:0]         abs_in [NumCh];

   logic                    p3_valid_ff;
   logic [ProdW-1:0]        p3_prod_ff [NumCh];
   logic                    p3_neg_ff  [NumCh];
   imao_pkg::tag_type       p3_tag_ff;

   logic [AvgW-1:0]         quot [NumCh];
   logic signed [AvgW-1:0]  avg  [NumCh];
   logic signed [DiffW-1:0] diff [NumGyro];
   imao_pkg::gyro_vec_type  gyro_sat;
   imao_pkg::rsp_type       result;

   imao_pkg::bias_upd_type  bias_upd;
   imao_pkg::bias_stat_type bias_stat;

   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign req_stall = hold || ((fill_ff == FillW'(FifoDepth)) && !rsp_xfer);
   assign req_xfer  = req_valid && !req_stall;

   // phase sequencer, next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      unique case (phase_ff)
         imao_pkg::PH_WARM: begin
            if (req_xfer) begin
               if (count_ff == WarmLast) begin
                  phase_in = imao_pkg::PH_ACC;
                  count_in = '0;
               end else begin
                  count_in = count_ff + CountW'(1);
               end
            end
         end
         imao_pkg::PH_ACC: begin
            if (req_xfer) begin
               if (count_ff == CalibLast) begin
                  phase_in = imao_pkg::PH_LATCH;
                  count_in = '0;
               end else begin
                  count_in = count_ff + CountW'(1);
               end
            end
         end
         imao_pkg::PH_LATCH: begin
            if (bias_stat.done) begin
               phase_in = imao_pkg::PH_DONE;
            end
         end
         imao_pkg::PH_DONE: begin
            phase_in = imao_pkg::PH_DONE;
         end
      endcase
   end

   // phase sequencer, outputs
   always_comb begin
      hold       = 1'b0;
      tag_in     = '0;
      tag_in.calib = 1'b1;
      unique case (phase_ff)
         imao_pkg::PH_WARM: begin
         end
         imao_pkg::PH_ACC: begin
            tag_in.acc  = 1'b1;
            tag_in.last = (count_ff == CalibLast);
         end
         imao_pkg::PH_LATCH: begin
            hold = 1'b1;
         end
         imao_pkg::PH_DONE: begin
            tag_in.calib = 1'b0;
         end
      endcase
   end

   always_comb begin
      slot_in = slot_ff;
      if (req_xfer) begin
         slot_in = (slot_ff == SlotW'(WINDOW - 1)) ? '0 : slot_ff + SlotW'(1);
      end
      fill_in = fill_ff;
      if (req_xfer && !rsp_xfer) begin
         fill_in = fill_ff + FillW'(1);
      end else if (rsp_xfer && !req_xfer) begin
         fill_in = fill_ff - FillW'(1);
      end
   end

   assign samp_in = {req_data.accel_z_raw, req_data.accel_y_raw, req_data.accel_x_raw,
                     req_data.gyro_z_raw, req_data.gyro_y_raw, req_data.gyro_x_raw};

   imao_ring_mem #(
      .WINDOW (WINDOW)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_slot (slot_ff),
      .rd_data (old_samp),
      .wr_en   (p1_valid_ff),
      .wr_slot (p1_slot_ff),
      .wr_data (p1_samp_ff)
   );

   // running window sums
   always_comb begin
      for (int c = 0; c < NumCh; c++) begin
         sums_in[c] = sums_ff[c] - SumW'($signed(old_samp[c])) + SumW'($signed(p1_samp_ff[c]));
      end
   end

   always_comb begin
      for (int c = 0; c < NumCh; c++) begin
         abs_in[c] = p2_sum_ff[c][SumW-1] ? SumW'(-p2_sum_ff[c]) : SumW'(p2_sum_ff[c]);
      end
   end

   // quotient, sign, offset and saturation
   always_comb begin
      for (int c = 0; c < NumCh; c++) begin
         quot[c] = {1'b0, p3_prod_ff[c][WinShift +: SampW]};
         avg[c]  = p3_neg_ff[c] ? $signed(~quot[c] + AvgW'(1)) : $signed(quot[c]);
      end
      for (int c = 0; c < NumGyro; c++) begin
         diff[c] = DiffW'(avg[c]) - DiffW'($signed(bias_stat.offset[c]));
         if (diff[c] > SatMax) begin
            gyro_sat[c] = SampW'(SatMax);
         end else if (diff[c] < SatMin) begin
            gyro_sat[c] = SampW'(SatMin);
         end else begin
            gyro_sat[c] = diff[c][SampW-1:0];
         end
      end
   end

   always_comb begin
      result.gyro_x_out  = gyro_sat[0];
      result.gyro_y_out  = gyro_sat[1];
      result.gyro_z_out  = gyro_sat[2];
      result.accel_x_out = avg[3][SampW-1:0];
      result.accel_y_out = avg[4][SampW-1:0];
      result.accel_z_out = avg[5][SampW-1:0];
      result.calibrating = p3_tag_ff.calib;
   end

   assign bias_upd.acc_en = p3_valid_ff && p3_tag_ff.acc;
   assign bias_upd.last   = p3_tag_ff.last;
   assign bias_upd.g      = gyro_sat;

   imao_bias_cal #(
      .CALIB (CALIB)
   ) u_bias (
      .clock (clock),
      .reset (reset),
      .upd   (bias_upd),
      .stat  (bias_stat)
   );

   imao_out_fifo #(
      .DEPTH (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (p3_valid_ff),
      .push_data (result),
      .pop       (rsp_xfer),
      .not_empty (rsp_valid),
      .head_data (rsp_data)
   );

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         p1_samp_ff <= samp_in;
         p1_slot_ff <= slot_ff;
         p1_tag_ff  <= tag_in;
      end
      p2_tag_ff <= p1_tag_ff;
      p3_tag_ff <= p2_tag_ff;
      for (int c = 0; c < NumCh; c++) begin
         p2_sum_ff[c]  <= sums_in[c];
         p3_prod_ff[c] <= ProdW'(abs_in[c]) * ProdW'(WinRecip);
         p3_neg_ff[c]  <= p2_sum_ff[c][SumW-1];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= (WARMUP == 0) ? imao_pkg::PH_ACC : imao_pkg::PH_WARM;
         count_ff    <= '0;
         slot_ff     <= '0;
         fill_ff     <= '0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         for (int c = 0; c < NumCh; c++) begin
            sums_ff[c] <= '0;
         end
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         slot_ff     <= slot_in;
         fill_ff     <= fill_in;
         p1_valid_ff <= req_xfer;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         if (p1_valid_ff) begin
            for (int c = 0; c < NumCh; c++) begin
               sums_ff[c] <= sums_in[c];
            end
         end
      end
   end

endmodule

// File: tb/imu_moving_average_offset_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for imu_moving_average_offset_core: window averages,
// gyro bias calibration after warm-up and saturation against the latched offsets
// depends on imao_pkg and the core under src
module imu_moving_average_offset_core_tb;

   localparam int NUM_SAMPLES = 950;
   localparam int CYCLE_LIMIT = 500000;
   localparam int NUM_CH      = imao_pkg::NUM_CH;
   localparam int NUM_GYRO    = imao_pkg::NUM_GYRO;
   localparam int SAMP_W      = imao_pkg::SAMP_W;
   localparam int WINDOW_DEF  = imao_pkg::WINDOW_DEF;
   localparam int CALIB_DEF   = imao_pkg::CALIB_DEF;
   localparam int WARMUP_DEF  = imao_pkg::WARMUP_DEF;
   localparam int RSP_W       = $bits(imao_pkg::rsp_type);
   localparam int BIAS_START  = (WARMUP_DEF > 20) ? WARMUP_DEF - 20 : 0;
   localparam int BIAS_END    = WARMUP_DEF + CALIB_DEF;

   typedef struct {
      imao_pkg::req_type data;
      bit                drain;
   } queued_sample_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   imao_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   imao_pkg::rsp_type rsp_data;

   queued_sample_type sample_queue[$];
   imao_pkg::rsp_type expected_filtered[$];
   imao_pkg::req_type cur_sample;

   // filter model state
   int                  ring_hist [NUM_CH][WINDOW_DEF];
   int                  ring_slot;
   int                  run_sum [NUM_CH];
   imao_pkg::phase_type cal_phase = (WARMUP_DEF == 0) ? imao_pkg::PH_ACC : imao_pkg::PH_WARM;
   int                  phase_cnt;
   int                  bias_sum [NUM_GYRO];
   int                  gyro_offset [NUM_GYRO];

   int  sent_count, recv_count, error_count, cycle_count;
   int  calibrated_count, sat_count, send_gap, stall_left;
   bit  req_quiet, rsp_quiet;

   string out_names [NUM_CH] = '{"gyro_x_out", "gyro_y_out", "gyro_z_out",
                                 "accel_x_out", "accel_y_out", "accel_z_out"};

   imu_moving_average_offset_core #(
      .WINDOW(WINDOW_DEF),
      .CALIB (CALIB_DEF),
      .WARMUP(WARMUP_DEF)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int idle_len(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic imao_pkg::req_type same_on_all(int v);
      return '{v[15:0], v[15:0], v[15:0], v[15:0], v[15:0], v[15:0]};
   endfunction

   task automatic push_sample(input imao_pkg::req_type d, input bit drain);
      queued_sample_type q;
      q.data  = d;
      q.drain = drain;
      sample_queue.push_back(q);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at result %0d: %s got %0d expected %0d", recv_count, what, got, want);
      error_count++;
   endtask

   task automatic predict_filtered(input imao_pkg::req_type s);
      int                raw [NUM_CH];
      int                avg [NUM_CH];
      int                g [NUM_GYRO];
      int                diff;
      imao_pkg::rsp_type r;
      raw[0] = $signed(s.gyro_x_raw);
      raw[1] = $signed(s.gyro_y_raw);
      raw[2] = $signed(s.gyro_z_raw);
      raw[3] = $signed(s.accel_x_raw);
      raw[4] = $signed(s.accel_y_raw);
      raw[5] = $signed(s.accel_z_raw);
      for (int c = 0; c < NUM_CH; c++) begin
         run_sum[c] = run_sum[c] - ring_hist[c][ring_slot] + raw[c];
         ring_hist[c][ring_slot] = raw[c];
         avg[c] = run_sum[c] / WINDOW_DEF;
      end
      ring_slot = (ring_slot + 1) % WINDOW_DEF;
      for (int c = 0; c < NUM_GYRO; c++) begin
         diff = avg[c] - gyro_offset[c];
         g[c] = (diff > 32767) ? 32767 : (diff < -32768) ? -32768 : diff;
         if (g[c] != diff) sat_count++;
      end
      r.gyro_x_out  = g[0][15:0];
      r.gyro_y_out  = g[1][15:0];
      r.gyro_z_out  = g[2][15:0];
      r.accel_x_out = avg[3][15:0];
      r.accel_y_out = avg[4][15:0];
      r.accel_z_out = avg[5][15:0];
      r.calibrating = (cal_phase != imao_pkg::PH_DONE);
      if (cal_phase == imao_pkg::PH_DONE) calibrated_count++;
      // the sample that completes accumulation still sees zero offsets
      if (cal_phase == imao_pkg::PH_WARM) begin
         phase_cnt++;
         if (phase_cnt >= WARMUP_DEF) begin
            cal_phase = imao_pkg::PH_ACC;
            phase_cnt = 0;
         end
      end else if (cal_phase == imao_pkg::PH_ACC) begin
         for (int c = 0; c < NUM_GYRO; c++) bias_sum[c] += g[c];
         phase_cnt++;
         if (phase_cnt >= CALIB_DEF) begin
            for (int c = 0; c < NUM_GYRO; c++) gyro_offset[c] = bias_sum[c] / CALIB_DEF;
            cal_phase = imao_pkg::PH_DONE;
            phase_cnt = 0;
         end
      end
      expected_filtered.push_back(r);
   endtask

   // sender
   always @(posedge clock) begin : drive
      logic              hold_valid;
      queued_sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         hold_valid = req_valid;
         if (req_valid && !req_stall) begin
            predict_filtered(cur_sample);
            sent_count++;
            hold_valid = 1'b0;
            if ($urandom_range(0, 49) == 0) req_quiet = !req_quiet;
            send_gap = idle_len(req_quiet);
         end
         if (!hold_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (sample_queue.size() > 0 &&
                         !(sample_queue[0].drain && recv_count != sent_count)) begin
               nxt = sample_queue.pop_front();
               cur_sample = nxt.data;
               req_data <= nxt.data;
               hold_valid = 1'b1;
            end
         end
         req_valid <= hold_valid;
      end
   end

   // receiver and checker
   always @(posedge clock) begin : watch
      imao_pkg::rsp_type    want;
      logic [RSP_W-1:0]     got_w, want_w;
      logic                 nxt_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_filtered.size() == 0) begin
               report_mismatch("transfer with no expectation", $signed(rsp_data.gyro_x_out), 0);
            end else begin
               want = expected_filtered.pop_front();
               got_w = rsp_data;
               want_w = want;
               for (int i = 0; i < NUM_CH; i++)
                  if (got_w[RSP_W-1-SAMP_W*i -: SAMP_W] !== want_w[RSP_W-1-SAMP_W*i -: SAMP_W])
                     report_mismatch(out_names[i], $signed(got_w[RSP_W-1-SAMP_W*i -: SAMP_W]),
                                     $signed(want_w[RSP_W-1-SAMP_W*i -: SAMP_W]));
               if (rsp_data.calibrating !== want.calibrating)
                  report_mismatch("calibrating", rsp_data.calibrating, want.calibrating);
            end
            recv_count++;
         end
         if (stall_left > 0) begin
            stall_left--;
            nxt_stall = 1'b1;
         end else begin
            if ($urandom_range(0, 99) == 0) rsp_quiet = !rsp_quiet;
            stall_left = idle_len(rsp_quiet);
            nxt_stall = (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
         rsp_stall <= nxt_stall;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d results seen",
                  cycle_count, recv_count, sent_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int                run_left, run_val, r, v;
      imao_pkg::req_type d;
      logic [15:0]       corners [5];
      corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};

      // directed: extremes, bit patterns, negative truncation, full rings
      push_sample(same_on_all(0), 1'b0);
      push_sample(same_on_all(32767), 1'b0);
      push_sample(same_on_all(-32768), 1'b0);
      push_sample('{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa}, 1'b0);
      push_sample('{16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555}, 1'b0);
      push_sample(same_on_all(1), 1'b0);
      push_sample(same_on_all(-1), 1'b0);
      repeat (3) push_sample(same_on_all(-7), 1'b0);
      repeat (WINDOW_DEF) push_sample(same_on_all(-32768), 1'b0);
      repeat (3) push_sample(same_on_all(32767), 1'b0);

      // random: biased gyro around calibration so the x and y offsets are large
      for (int n = sample_queue.size(); n < NUM_SAMPLES; n++) begin
         d = {$urandom, $urandom, $urandom};
         if (n >= BIAS_START && n < BIAS_END) begin
            v = $urandom_range(24000, 32767);
            d.gyro_x_raw = v[15:0];
            v = -$urandom_range(24000, 32768);
            d.gyro_y_raw = v[15:0];
            v = $urandom_range(0, 4000) - 2000;
            d.gyro_z_raw = v[15:0];
         end else if (n >= BIAS_END) begin
            if (run_left > 0) begin
               d = same_on_all(run_val);
               run_left--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 8) begin
                  // constant extremes drive the gyro outputs into saturation against the offsets
                  run_val = $urandom_range(0, 1) ? 32767 : -32768;
                  run_left = $urandom_range(10, 14);
                  d = same_on_all(run_val);
               end else if (r < 25) begin
                  d = '{corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)],
                        corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)],
                        corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)]};
               end
            end
         end
         push_sample(d, (n == BIAS_END) || ($urandom_range(0, 99) == 0));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (sample_queue.size() != 0 || req_valid || recv_count != sent_count)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_filtered.size() != 0)
         report_mismatch("results never seen", 0, expected_filtered.size());

      $display("ran %0d samples through warm-up and bias calibration, %0d with offsets applied",
               sent_count, calibrated_count);
      $display("gyro outputs clamped %0d times, %0d mismatches", sat_count, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/imao_pkg.sv
src/imao_ring_mem.sv
src/imao_bias_cal.sv
src/imao_out_fifo.sv
src/imu_moving_average_offset_core.sv
tb/imu_moving_average_offset_core_tb.sv
